// File: rtl/core/doubly_linked_list_with_cursor_unit_macros.svh
// Assertion macros shared by the list unit.
`ifndef DOUBLY_LINKED_LIST_WITH_CURSOR_UNIT_MACROS_SVH
`define DOUBLY_LINKED_LIST_WITH_CURSOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DLC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list unit check failed");

// Next-cycle implication, disabled while reset is high.
`define DLC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list unit check failed");

`endif

// File: rtl/core/dlc_pkg.sv
package dlc_pkg;

  localparam int NODE_COUNT = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int OP_W       = 4;
  localparam int STAT_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT  = 4'd0,
    OP_INS_BACK   = 4'd1,
    OP_INS_BEFORE = 4'd2,
    OP_INS_AFTER  = 4'd3,
    OP_DEL_FIRST  = 4'd4,
    OP_DEL_LAST   = 4'd5,
    OP_DEL_CUR    = 4'd6,
    OP_CUR_FIRST  = 4'd7,
    OP_CUR_LAST   = 4'd8,
    OP_PREV       = 4'd9,
    OP_NEXT       = 4'd10,
    OP_CLEAR      = 4'd11,
    OP_PEEK       = 4'd12
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OFF_END = 2'd2,
    ST_FULL    = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR1,
    S_WR2,
    S_VAL,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_INS_FRONT,
    K_INS_BACK,
    K_INS_BEFORE,
    K_INS_AFTER,
    K_DEL_FIRST,
    K_DEL_LAST,
    K_DEL_MID,
    K_PREV,
    K_NEXT
  } kind_t;

endpackage

// File: rtl/core/dlc_ram.sv
module dlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/doubly_linked_list_with_cursor_unit.sv
// One doubly linked list of signed values held in a pool of NODE_COUNT nodes, with a
// cursor that may sit on a node or be off the list. Each input item carries one operation
// and yields exactly one result item with a status, the length, cursor flags and the
// first, last and cursor values. Errors (empty list, cursor off the list, pool full)
// leave the state untouched. Values and the forward and backward links live in three
// single-port-read synchronous memories; head, tail, cursor, counters and the free list
// head are registers, and the first, last and cursor values are cached in registers so
// a result never needs a memory read of its own. Errors, peek, clear, the cursor jumps
// and a cursor step off either end go straight to the result; inserts, deletes and the
// other cursor steps first read a link (S_RD1, S_RD2), then do a dependent value read
// (S_VAL) or writes in S_WR1 and, for inserts in the middle, S_WR2, because each memory
// has one read and one write port. A new item is taken as soon as the previous one has
// reached the output register, even if that result is still waiting.
module doubly_linked_list_with_cursor_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [dlc_pkg::OP_W-1:0]               op,
  input  logic signed [dlc_pkg::DATA_WIDTH-1:0]  value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [dlc_pkg::STAT_W-1:0]             status,
  output logic [dlc_pkg::CNT_W-1:0]              length,
  output logic                                   cursor_on_list,
  output logic                                   off_end,
  output logic                                   at_first,
  output logic                                   at_last,
  output logic signed [dlc_pkg::DATA_WIDTH-1:0]  first_value,
  output logic signed [dlc_pkg::DATA_WIDTH-1:0]  last_value,
  output logic signed [dlc_pkg::DATA_WIDTH-1:0]  cursor_value
);

  import dlc_pkg::*;

  `include "doubly_linked_list_with_cursor_unit_macros.svh"

  // Control and list registers.
  state_t state, state_next;
  kind_t  kind, kind_next;
  stat_t  stat_q, stat_next;
  logic [IDX_W-1:0] head, tail, cur, fh, nn, fh_nx, tmp;
  logic             cv, fne;
  logic [CNT_W-1:0] cnt, nu;
  logic [DATA_WIDTH-1:0] val_q, first_val, last_val, cur_val;

  // Memory ports.
  logic                  v_we, v_re, f_we, f_re, b_we, b_re;
  logic [IDX_W-1:0]      v_wa, v_ra, f_wa, f_ra, b_wa, b_ra, f_wd, b_wd;
  logic [DATA_WIDTH-1:0] v_wd, v_rd;
  logic [IDX_W-1:0]      f_rd, b_rd;

  logic accept, empty, can_alloc, out_load;
  logic [CNT_W:0] cnt_p1;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign empty     = (cnt == '0);
  assign can_alloc = fne || (nu < CNT_W'(NODE_COUNT));
  assign cnt_p1    = {1'b0, cnt} + (CNT_W + 1)'(1);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Status and the work to do, decided from the registers when the item arrives.
  always_comb begin
    stat_next = ST_OK;
    kind_next = K_NONE;
    if ((op >= OP_INS_BEFORE) && (op <= OP_NEXT) && empty) begin
      stat_next = ST_EMPTY;
    end else if ((op == OP_INS_BEFORE || op == OP_INS_AFTER || op == OP_DEL_CUR ||
                  op == OP_PREV || op == OP_NEXT) && !cv) begin
      stat_next = ST_OFF_END;
    end else if ((op <= OP_INS_AFTER) && !can_alloc) begin
      stat_next = ST_FULL;
    end else begin
      case (op_t'(op))
        OP_INS_FRONT:  kind_next = K_INS_FRONT;
        OP_INS_BACK:   kind_next = K_INS_BACK;
        OP_INS_BEFORE: kind_next = (cur == head) ? K_INS_FRONT : K_INS_BEFORE;
        OP_INS_AFTER:  kind_next = (cur == tail) ? K_INS_BACK : K_INS_AFTER;
        OP_DEL_FIRST:  kind_next = K_DEL_FIRST;
        OP_DEL_LAST:   kind_next = K_DEL_LAST;
        OP_DEL_CUR: begin
          if (cur == head) begin
            kind_next = K_DEL_FIRST;
          end else if (cur == tail) begin
            kind_next = K_DEL_LAST;
          end else begin
            kind_next = K_DEL_MID;
          end
        end
        OP_PREV:       kind_next = (cur == head) ? K_NONE : K_PREV;
        OP_NEXT:       kind_next = (cur == tail) ? K_NONE : K_NEXT;
        default:       kind_next = K_NONE;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (kind_next == K_NONE) ? S_DONE : S_RD1;
        end
      end
      S_RD1: state_next = S_RD2;
      S_RD2: begin
        case (kind)
          K_DEL_FIRST, K_DEL_LAST: state_next = (cnt == CNT_W'(1)) ? S_DONE : S_VAL;
          K_PREV, K_NEXT:          state_next = S_VAL;
          default:                 state_next = S_WR1;
        endcase
      end
      S_WR1: begin
        state_next = (kind == K_INS_BEFORE || kind == K_INS_AFTER) ? S_WR2 : S_DONE;
      end
      S_WR2:  state_next = S_DONE;
      S_VAL:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory accesses of each step.
  always_comb begin
    v_we = 1'b0; v_wa = nn;  v_wd = val_q; v_re = 1'b0; v_ra = f_rd;
    f_we = 1'b0; f_wa = nn;  f_wd = cur;   f_re = 1'b0; f_ra = cur;
    b_we = 1'b0; b_wa = nn;  b_wd = cur;   b_re = 1'b0; b_ra = cur;
    case (state)
      S_RD1: begin
        case (kind)
          K_INS_FRONT, K_INS_BACK, K_INS_AFTER: begin
            f_re = 1'b1; f_ra = fh;
          end
          K_INS_BEFORE: begin
            f_re = 1'b1; f_ra = fh;
            b_re = 1'b1; b_ra = cur;
          end
          K_DEL_FIRST: begin
            f_re = 1'b1; f_ra = head;
          end
          K_DEL_LAST: begin
            b_re = 1'b1; b_ra = tail;
          end
          K_DEL_MID: begin
            f_re = 1'b1; f_ra = cur;
            b_re = 1'b1; b_ra = cur;
          end
          K_PREV: begin
            b_re = 1'b1; b_ra = cur;
          end
          K_NEXT: begin
            f_re = 1'b1; f_ra = cur;
          end
          default: ;
        endcase
      end
      S_RD2: begin
        case (kind)
          K_INS_AFTER: begin
            f_re = 1'b1; f_ra = cur;
          end
          K_DEL_FIRST: begin
            f_we = 1'b1; f_wa = head; f_wd = fh;
            v_re = 1'b1; v_ra = f_rd;
          end
          K_DEL_LAST: begin
            f_we = 1'b1; f_wa = tail; f_wd = fh;
            v_re = 1'b1; v_ra = b_rd;
          end
          K_DEL_MID: begin
            f_we = 1'b1; f_wa = b_rd; f_wd = f_rd;
            b_we = 1'b1; b_wa = f_rd; b_wd = b_rd;
          end
          K_PREV: begin
            v_re = 1'b1; v_ra = b_rd;
          end
          K_NEXT: begin
            v_re = 1'b1; v_ra = f_rd;
          end
          default: ;
        endcase
      end
      S_WR1: begin
        case (kind)
          K_INS_FRONT: begin
            v_we = 1'b1;
            f_we = !empty; f_wa = nn;   f_wd = head;
            b_we = !empty; b_wa = head; b_wd = nn;
          end
          K_INS_BACK: begin
            v_we = 1'b1;
            b_we = !empty; b_wa = nn;   b_wd = tail;
            f_we = !empty; f_wa = tail; f_wd = nn;
          end
          K_INS_BEFORE: begin
            v_we = 1'b1;
            f_we = 1'b1; f_wa = b_rd; f_wd = nn;
            b_we = 1'b1; b_wa = cur;  b_wd = nn;
          end
          K_INS_AFTER: begin
            v_we = 1'b1;
            f_we = 1'b1; f_wa = cur;  f_wd = nn;
            b_we = 1'b1; b_wa = f_rd; b_wd = nn;
          end
          K_DEL_MID: begin
            f_we = 1'b1; f_wa = cur; f_wd = fh;
          end
          default: ;
        endcase
      end
      S_WR2: begin
        case (kind)
          K_INS_BEFORE: begin
            f_we = 1'b1; f_wa = nn; f_wd = cur;
            b_we = 1'b1; b_wa = nn; b_wd = tmp;
          end
          K_INS_AFTER: begin
            b_we = 1'b1; b_wa = nn; b_wd = cur;
            f_we = 1'b1; f_wa = nn; f_wd = tmp;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  dlc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODE_COUNT)) u_values (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .re(v_re), .raddr(v_ra), .rdata(v_rd)
  );

  dlc_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_fwd (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .re(f_re), .raddr(f_ra), .rdata(f_rd)
  );

  dlc_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_bwd (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .re(b_re), .raddr(b_ra), .rdata(b_rd)
  );

  // List registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_NONE;
      head  <= '0;
      tail  <= '0;
      cur   <= '0;
      cv    <= 1'b0;
      cnt   <= '0;
      fh    <= '0;
      fne   <= 1'b0;
      nu    <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind   <= kind_next;
            stat_q <= stat_next;
            val_q  <= value;
            nn     <= fne ? fh : nu[IDX_W-1:0];
            if (stat_next == ST_OK) begin
              case (op_t'(op))
                OP_CUR_FIRST: begin
                  cur <= head; cv <= 1'b1; cur_val <= first_val;
                end
                OP_CUR_LAST: begin
                  cur <= tail; cv <= 1'b1; cur_val <= last_val;
                end
                OP_PREV: begin
                  if (cur == head) cv <= 1'b0;
                end
                OP_NEXT: begin
                  if (cur == tail) cv <= 1'b0;
                end
                OP_CLEAR: begin
                  cnt  <= '0;
                  nu   <= '0;
                  fh   <= '0;
                  fne  <= 1'b0;
                  head <= '0;
                  tail <= '0;
                  cur  <= '0;
                  cv   <= 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
        S_RD2: begin
          fh_nx <= f_rd;
          case (kind)
            K_DEL_FIRST: begin
              fh  <= head;
              fne <= 1'b1;
              cnt <= cnt - CNT_W'(1);
              if (cnt == CNT_W'(1)) begin
                head <= '0;
                tail <= '0;
                cv   <= 1'b0;
              end else begin
                head <= f_rd;
                if (cur == head) cv <= 1'b0;
              end
            end
            K_DEL_LAST: begin
              fh  <= tail;
              fne <= 1'b1;
              cnt <= cnt - CNT_W'(1);
              if (cnt == CNT_W'(1)) begin
                head <= '0;
                tail <= '0;
                cv   <= 1'b0;
              end else begin
                tail <= b_rd;
                if (cur == tail) cv <= 1'b0;
              end
            end
            K_PREV: cur <= b_rd;
            K_NEXT: cur <= f_rd;
            default: ;
          endcase
        end
        S_WR1: begin
          case (kind)
            K_INS_FRONT, K_INS_BACK, K_INS_BEFORE, K_INS_AFTER: begin
              if (fne) begin
                fh  <= fh_nx;
                fne <= ({1'b0, nu} > cnt_p1);
              end else begin
                nu <= nu + CNT_W'(1);
              end
              cnt <= cnt_p1[CNT_W-1:0];
              tmp <= (kind == K_INS_BEFORE) ? b_rd : f_rd;
              if (kind == K_INS_FRONT) begin
                head      <= nn;
                first_val <= val_q;
                if (empty) begin
                  tail     <= nn;
                  last_val <= val_q;
                end
              end
              if (kind == K_INS_BACK) begin
                tail     <= nn;
                last_val <= val_q;
                if (empty) begin
                  head      <= nn;
                  first_val <= val_q;
                end
              end
            end
            K_DEL_MID: begin
              cv  <= 1'b0;
              fh  <= cur;
              fne <= 1'b1;
              cnt <= cnt - CNT_W'(1);
            end
            default: ;
          endcase
        end
        S_VAL: begin
          case (kind)
            K_DEL_FIRST:    first_val <= v_rd;
            K_DEL_LAST:     last_val  <= v_rd;
            K_PREV, K_NEXT: cur_val   <= v_rd;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Output register: holds a finished result while the next item is already taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= stat_q;
      length         <= cnt;
      cursor_on_list <= cv;
      off_end        <= !empty && !cv;
      at_first       <= cv && (cur == head);
      at_last        <= cv && (cur == tail);
      first_value    <= empty ? '0 : first_val;
      last_value     <= empty ? '0 : last_val;
      cursor_value   <= cv ? cur_val : '0;
    end
  end

  `DLC_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, state != S_IDLE)
  `DLC_ASSERT_IMPL(a_cursor_needs_nodes, clk, rst, cv, cnt != '0)
  `DLC_ASSERT_IMPL(a_free_list_has_nodes, clk, rst, fne, nu > cnt)
  `DLC_ASSERT_IMPL(a_count_within_used, clk, rst, 1'b1, cnt <= nu)

endmodule

// File: sim/doubly_linked_list_with_cursor_unit_test.sv
`timescale 1ns / 100ps

module doubly_linked_list_with_cursor_unit_test;
  import dlc_pkg::*;

  // Expected results for the list unit. It keeps its own copy of the list as
  // a pool with links, a free list and an untouched count, exactly as the
  // block is meant to, and queues one expected result per accepted item.
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  length;
    logic        cursor_on_list;
    logic        off_end;
    logic        at_first;
    logic        at_last;
    logic [31:0] first_value;
    logic [31:0] last_value;
    logic [31:0] cursor_value;
  } list_result_t;

  class list_scoreboard;
    logic [31:0] vals[256];
    logic [7:0]  fwd[256];
    logic [7:0]  bwd[256];
    logic [7:0]  head, tail, cur, free_head;
    logic        cur_ok, free_any;
    int          count, fresh;
    list_result_t pending[$];
    int          mismatches;

    function void clear_state();
      head = 0; tail = 0; cur = 0; free_head = 0;
      cur_ok = 0; free_any = 0; count = 0; fresh = 0;
    endfunction

    function logic [7:0] grab(logic [31:0] v);
      logic [7:0] n;
      if (free_any) begin
        n = free_head;
        free_head = fwd[n];
        free_any = fresh > count + 1;
      end else begin
        n = fresh[7:0];
        fresh++;
      end
      vals[n] = v; fwd[n] = 0; bwd[n] = 0;
      count++;
      return n;
    endfunction

    function void drop(logic [7:0] n);
      fwd[n] = free_head;
      free_head = n;
      free_any = 1;
      count--;
    endfunction

    function void add_front(logic [31:0] v);
      logic [7:0] n;
      n = grab(v);
      if (count == 1) begin
        head = n; tail = n;
      end else begin
        fwd[n] = head; bwd[head] = n; head = n;
      end
    endfunction

    function void add_back(logic [31:0] v);
      logic [7:0] n;
      n = grab(v);
      if (count == 1) begin
        head = n; tail = n;
      end else begin
        bwd[n] = tail; fwd[tail] = n; tail = n;
      end
    endfunction

    function void remove_first();
      logic [7:0] o;
      o = head;
      if (cur_ok && cur == o) cur_ok = 0;
      if (count == 1) begin
        drop(o); head = 0; tail = 0; cur_ok = 0;
      end else begin
        head = fwd[o]; drop(o);
      end
    endfunction

    function void remove_last();
      logic [7:0] o;
      o = tail;
      if (cur_ok && cur == o) cur_ok = 0;
      if (count == 1) begin
        drop(o); head = 0; tail = 0; cur_ok = 0;
      end else begin
        tail = bwd[o]; drop(o);
      end
    endfunction

    // Applies one accepted item and queues the result it should give.
    function void note_item(logic [3:0] code, logic [31:0] v);
      list_result_t r;
      logic [7:0] p, n;
      logic empty, at_cursor, is_ins;
      empty = count == 0;
      at_cursor = code inside {OP_INS_BEFORE, OP_INS_AFTER, OP_DEL_CUR, OP_PREV, OP_NEXT};
      is_ins = code <= OP_INS_AFTER;
      r.status = ST_OK;
      if (empty && (at_cursor || code inside {OP_DEL_FIRST, OP_DEL_LAST, OP_CUR_FIRST,
                                              OP_CUR_LAST}))
        r.status = ST_EMPTY;
      else if (at_cursor && !cur_ok)
        r.status = ST_OFF_END;
      else if (is_ins && !free_any && fresh >= 256)
        r.status = ST_FULL;
      else begin
        case (code)
          OP_INS_FRONT: add_front(v);
          OP_INS_BACK:  add_back(v);
          OP_INS_BEFORE: begin
            if (cur == head) add_front(v);
            else begin
              p = bwd[cur]; n = grab(v);
              fwd[p] = n; bwd[cur] = n; fwd[n] = cur; bwd[n] = p;
            end
          end
          OP_INS_AFTER: begin
            if (cur == tail) add_back(v);
            else begin
              p = fwd[cur]; n = grab(v);
              fwd[cur] = n; bwd[p] = n; bwd[n] = cur; fwd[n] = p;
            end
          end
          OP_DEL_FIRST: remove_first();
          OP_DEL_LAST:  remove_last();
          OP_DEL_CUR: begin
            if (cur == head) remove_first();
            else if (cur == tail) remove_last();
            else begin
              p = bwd[cur]; n = fwd[cur];
              cur_ok = 0; fwd[p] = n; bwd[n] = p; drop(cur);
            end
          end
          OP_CUR_FIRST: begin cur = head; cur_ok = 1; end
          OP_CUR_LAST:  begin cur = tail; cur_ok = 1; end
          OP_PREV: begin
            if (cur == head) cur_ok = 0; else cur = bwd[cur];
          end
          OP_NEXT: begin
            if (cur == tail) cur_ok = 0; else cur = fwd[cur];
          end
          OP_CLEAR: clear_state();
          default: ;
        endcase
      end
      empty = count == 0;
      r.length = count[8:0];
      r.cursor_on_list = cur_ok;
      r.off_end = !empty && !cur_ok;
      r.at_first = cur_ok && cur == head;
      r.at_last = cur_ok && cur == tail;
      r.first_value = empty ? 32'd0 : vals[head];
      r.last_value = empty ? 32'd0 : vals[tail];
      r.cursor_value = cur_ok ? vals[cur] : 32'd0;
      pending.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: status %0d", got.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d len=%0d on=%b off=%b f=%b l=%b fv=%h lv=%h cv=%h\n%s",
            want.status, want.length, want.cursor_on_list, want.off_end, want.at_first,
            want.at_last, want.first_value, want.last_value, want.cursor_value,
            $sformatf("     got st=%0d len=%0d on=%b off=%b f=%b l=%b fv=%h lv=%h cv=%h",
            got.status, got.length, got.cursor_on_list, got.off_end, got.at_first,
            got.at_last, got.first_value, got.last_value, got.cursor_value));
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [3:0] op;
  logic signed [31:0] value;
  logic [1:0] status;
  logic [8:0] length;
  logic cursor_on_list, off_end, at_first, at_last;
  logic signed [31:0] first_value, last_value, cursor_value;

  list_scoreboard board;

  // Idle rates in percent for the two sides; changed between phases.
  int send_idle, recv_idle;
  // When set, the receiver holds off completely for a long stretch.
  bit hold_recv;
  int quiet_cycles;

  doubly_linked_list_with_cursor_unit dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver side: ready toggles at random, and every accepted result is
  // checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready)
        board.check_result('{status, length, cursor_on_list, off_end, at_first, at_last,
                             first_value, last_value, cursor_value});
      out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: counts cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("doubly_linked_list_with_cursor_unit regression: fail");
        $finish;
      end
    end
  end

  // Offers one item, possibly after random idle cycles, and waits until it
  // is taken. Valid stays high across back-to-back items.
  task automatic send_item(logic [3:0] code, logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    op <= code;
    value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_item(code, v);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly cursor work and inserts on a live list, with fewer deletes, some clears and
  // the odd peek or unused code, so the list grows to a useful size.
  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 4'($urandom_range(OP_INS_FRONT, OP_INS_AFTER));
    if (r < 55) return 4'($urandom_range(OP_DEL_FIRST, OP_DEL_CUR));
    if (r < 90) return 4'($urandom_range(OP_CUR_FIRST, OP_NEXT));
    if (r < 92) return OP_CLEAR;
    return 4'($urandom_range(OP_PEEK, 15));
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_item(pick_op(), $urandom());
  endtask

  initial begin
    board = new();
    board.clear_state();
    board.mismatches = 0;
    rst = 1; in_valid = 0; op = OP_PEEK; value = 0;
    send_idle = 0; recv_idle = 0; hold_recv = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every operation code in turn from an empty list, the cursor off the list,
    // extreme values, moving past both ends and deleting the cursor node.
    for (int c = 0; c < 16; c++) send_item(4'(c), 32'h0);
    send_item(OP_INS_FRONT, 32'h8000_0000);
    send_item(OP_INS_BACK, 32'h7fff_ffff);
    send_item(OP_INS_BEFORE, 32'hffff_ffff);
    send_item(OP_NEXT, 0);
    send_item(OP_CUR_LAST, 0);
    send_item(OP_NEXT, 0);
    send_item(OP_CUR_FIRST, 0);
    send_item(OP_PREV, 0);
    send_item(OP_CUR_FIRST, 0);
    send_item(OP_INS_AFTER, 32'h5555_aaaa);
    send_item(OP_NEXT, 0);
    send_item(OP_DEL_CUR, 0);
    send_item(OP_DEL_CUR, 0);
    wait_drained();

    // Fill the pool to the end, hit the full case, then recycle freed nodes.
    for (int i = 0; i < 256; i++) send_item(OP_INS_BACK, $urandom());
    send_item(OP_INS_FRONT, 1);
    send_item(OP_CUR_FIRST, 0);
    send_item(OP_INS_AFTER, 2);
    for (int i = 0; i < 6; i++) send_item(4'($urandom_range(OP_DEL_FIRST, OP_DEL_CUR)), 0);
    for (int i = 0; i < 6; i++) send_item(4'($urandom_range(OP_INS_FRONT, OP_INS_AFTER)),
                                          $urandom());
    send_item(OP_CLEAR, 0);
    wait_drained();

    // Random phases with different idling on each side.
    random_run(20);
    send_idle = 75; recv_idle = 0;
    random_run(20);
    wait_drained();
    send_idle = 0; recv_idle = 75;
    random_run(20);
    send_idle = 29; recv_idle = 29;
    random_run(20);

    // Long receiver hold-off while the sender keeps offering items.
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_recv = 1;
        repeat (200) @(posedge clk);
        hold_recv = 0;
      end
      random_run(20);
    join
    wait_drained();

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("doubly_linked_list_with_cursor_unit regression: pass");
    else
      $display("doubly_linked_list_with_cursor_unit regression: fail");
    $finish;
  end
endmodule
